### rtl/jeti_pkg.sv
// ----------------------------------------------------------------------------
// jeti_pkg
// shared constants, register codes and the per-slot control word of the
// escape-time iterator
// ----------------------------------------------------------------------------
`default_nettype none

package jeti_pkg;

    // default geometry of the coordinates
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 28;

    // iteration count and result width
    localparam int COUNT_W = 16;

    // register stages in one pass round the iteration loop
    localparam int PIPE_STAGES = 5;

    // sequence tag, wide enough to tell apart every item in the loop
    localparam int TAG_W = $clog2(PIPE_STAGES) + 1;

    // configuration port
    localparam int CFG_IDX_W = 2;

    localparam logic [63:0]        RADIUS_SQ_RESET = 64'd1073741824;
    localparam logic [COUNT_W-1:0] MAX_ITERS_RESET = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C_RE         = 2'd0,
        REG_C_IM         = 2'd1,
        REG_RADIUS_SQ    = 2'd2,
        REG_MAX_ITERS    = 2'd3
    } cfg_reg_t;

    // control word that travels round the loop with each item
    typedef struct packed {
        logic               valid;
        logic               done;
        logic [COUNT_W-1:0] count;
        logic [TAG_W-1:0]   tag;
    } slot_t;

endpackage : jeti_pkg

`default_nettype wire

### rtl/jeti_step.sv
// ----------------------------------------------------------------------------
// jeti_step
// five-stage pipelined escape test and complex square, adding c_re and
// subtracting c_im, one pass of the iteration loop
// ----------------------------------------------------------------------------
`default_nettype none

module jeti_step
    import jeti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slot_t                         in_ctrl,
    input  logic signed [COORD_WIDTH+3:0] in_re,
    input  logic signed [COORD_WIDTH+3:0] in_im,
    input  logic signed [COORD_WIDTH-1:0] c_re,
    input  logic signed [COORD_WIDTH-1:0] c_im,
    input  logic [COORD_WIDTH+1:0]        radius_sq,
    output slot_t                         out_ctrl,
    output logic signed [COORD_WIDTH+3:0] out_re,
    output logic signed [COORD_WIDTH+3:0] out_im,
    output logic                          out_escaped
);

    localparam int ZW   = COORD_WIDTH + 4;        // working z
    localparam int MW   = COORD_WIDTH + 3;        // magnitude of working z
    localparam int HW   = (MW + 1) / 2;           // low half of a magnitude
    localparam int HIW  = MW - HW;                // high half
    localparam int PW   = 2 * MW;                 // full product
    localparam int RW   = COORD_WIDTH + 2;        // squared radius
    localparam int DW   = PW + 1;                 // re^2 - im^2
    localparam int TW   = PW + 2;                 // +/- 2*re*im
    localparam int CMPW = (PW + 1 > RW + FRAC_BITS) ? PW + 1 : RW + FRAC_BITS;

    // stage 1: magnitudes and sign of the cross term
    slot_t          p1_ctrl_reg;
    logic [MW-1:0]  p1_re_mag_reg;
    logic [MW-1:0]  p1_im_mag_reg;
    logic           p1_neg_reg;
    logic [MW-1:0]  re_mag_next;
    logic [MW-1:0]  im_mag_next;

    // stage 2: half-width partial products
    slot_t                p2_ctrl_reg;
    logic                 p2_neg_reg;
    logic [2*HW-1:0]      p2_rr_ll_reg;
    logic [HW+HIW-1:0]    p2_rr_lh_reg;
    logic [2*HIW-1:0]     p2_rr_hh_reg;
    logic [2*HW-1:0]      p2_ii_ll_reg;
    logic [HW+HIW-1:0]    p2_ii_lh_reg;
    logic [2*HIW-1:0]     p2_ii_hh_reg;
    logic [2*HW-1:0]      p2_ri_ll_reg;
    logic [HW+HIW-1:0]    p2_ri_lh_reg;
    logic [HW+HIW-1:0]    p2_ri_hl_reg;
    logic [2*HIW-1:0]     p2_ri_hh_reg;
    logic [HW-1:0]        re_lo;
    logic [HIW-1:0]       re_hi;
    logic [HW-1:0]        im_lo;
    logic [HIW-1:0]       im_hi;

    // stage 3: full products
    slot_t          p3_ctrl_reg;
    logic           p3_neg_reg;
    logic [PW-1:0]  p3_rr_reg;
    logic [PW-1:0]  p3_ii_reg;
    logic [PW-1:0]  p3_ri_reg;

    // stage 4: escape test, difference and doubled cross term
    slot_t                p4_ctrl_reg;
    logic                 p4_esc_reg;
    logic signed [DW-1:0] p4_diff_reg;
    logic signed [TW-1:0] p4_dbl_reg;
    logic [PW:0]          mag_sum;
    logic [CMPW-1:0]      threshold;
    logic                 esc_next;
    logic signed [DW-1:0] diff_next;
    logic [TW-1:0]        dbl_mag;
    logic signed [TW-1:0] dbl_next;

    // stage 5: scale back, add c_re and subtract c_im
    slot_t                p5_ctrl_reg;
    logic                 p5_esc_reg;
    logic signed [ZW-1:0] p5_re_reg;
    logic signed [ZW-1:0] p5_im_reg;
    logic signed [DW-1:0] diff_sh;
    logic signed [TW-1:0] dbl_sh;
    logic signed [ZW-1:0] re_next;
    logic signed [ZW-1:0] im_next;

    always_comb
    begin
        re_mag_next = in_re[ZW-1] ? MW'(-in_re) : MW'(in_re);
        im_mag_next = in_im[ZW-1] ? MW'(-in_im) : MW'(in_im);
    end

    assign re_lo = p1_re_mag_reg[HW-1:0];
    assign re_hi = p1_re_mag_reg[MW-1:HW];
    assign im_lo = p1_im_mag_reg[HW-1:0];
    assign im_hi = p1_im_mag_reg[MW-1:HW];

    always_comb
    begin
        mag_sum   = {1'b0, p3_rr_reg} + {1'b0, p3_ii_reg};
        threshold = CMPW'(radius_sq) << FRAC_BITS;
        esc_next  = CMPW'(mag_sum) > threshold;
        diff_next = $signed({1'b0, p3_rr_reg}) - $signed({1'b0, p3_ii_reg});
        dbl_mag   = {1'b0, p3_ri_reg, 1'b0};
        dbl_next  = p3_neg_reg ? -$signed(dbl_mag) : $signed(dbl_mag);
    end

    // arithmetic shift is the floor of the division
    always_comb
    begin
        diff_sh = p4_diff_reg >>> FRAC_BITS;
        dbl_sh  = p4_dbl_reg >>> FRAC_BITS;
        re_next = ZW'(diff_sh) + ZW'(c_re);
        im_next = ZW'(dbl_sh) - ZW'(c_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctrl_reg <= '0;
            p2_ctrl_reg <= '0;
            p3_ctrl_reg <= '0;
            p4_ctrl_reg <= '0;
            p5_ctrl_reg <= '0;
        end
        else
        begin
            p1_ctrl_reg <= in_ctrl;
            p2_ctrl_reg <= p1_ctrl_reg;
            p3_ctrl_reg <= p2_ctrl_reg;
            p4_ctrl_reg <= p3_ctrl_reg;
            p5_ctrl_reg <= p4_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_re_mag_reg <= re_mag_next;
        p1_im_mag_reg <= im_mag_next;
        p1_neg_reg    <= in_re[ZW-1] ^ in_im[ZW-1];

        p2_neg_reg   <= p1_neg_reg;
        p2_rr_ll_reg <= {{HW{1'b0}}, re_lo} * {{HW{1'b0}}, re_lo};
        p2_rr_lh_reg <= {{HIW{1'b0}}, re_lo} * {{HW{1'b0}}, re_hi};
        p2_rr_hh_reg <= {{HIW{1'b0}}, re_hi} * {{HIW{1'b0}}, re_hi};
        p2_ii_ll_reg <= {{HW{1'b0}}, im_lo} * {{HW{1'b0}}, im_lo};
        p2_ii_lh_reg <= {{HIW{1'b0}}, im_lo} * {{HW{1'b0}}, im_hi};
        p2_ii_hh_reg <= {{HIW{1'b0}}, im_hi} * {{HIW{1'b0}}, im_hi};
        p2_ri_ll_reg <= {{HW{1'b0}}, re_lo} * {{HW{1'b0}}, im_lo};
        p2_ri_lh_reg <= {{HIW{1'b0}}, re_lo} * {{HW{1'b0}}, im_hi};
        p2_ri_hl_reg <= {{HW{1'b0}}, re_hi} * {{HIW{1'b0}}, im_lo};
        p2_ri_hh_reg <= {{HIW{1'b0}}, re_hi} * {{HIW{1'b0}}, im_hi};

        // squares use the cross partial twice
        p3_neg_reg <= p2_neg_reg;
        p3_rr_reg  <= PW'(p2_rr_ll_reg) + (PW'(p2_rr_lh_reg) << (HW + 1))
                      + (PW'(p2_rr_hh_reg) << (2 * HW));
        p3_ii_reg  <= PW'(p2_ii_ll_reg) + (PW'(p2_ii_lh_reg) << (HW + 1))
                      + (PW'(p2_ii_hh_reg) << (2 * HW));
        p3_ri_reg  <= PW'(p2_ri_ll_reg) + (PW'(p2_ri_lh_reg) << HW)
                      + (PW'(p2_ri_hl_reg) << HW) + (PW'(p2_ri_hh_reg) << (2 * HW));

        p4_esc_reg  <= esc_next;
        p4_diff_reg <= diff_next;
        p4_dbl_reg  <= dbl_next;

        p5_esc_reg <= p4_esc_reg;
        p5_re_reg  <= re_next;
        p5_im_reg  <= im_next;
    end

    assign out_ctrl    = p5_ctrl_reg;
    assign out_re      = p5_re_reg;
    assign out_im      = p5_im_reg;
    assign out_escaped = p5_esc_reg;

endmodule : jeti_step

`default_nettype wire

### rtl/julia_escape_time_iterator_core.sv
// ----------------------------------------------------------------------------
// julia_escape_time_iterator_core
// escape-time iteration count of a julia set for one starting point per beat
// ----------------------------------------------------------------------------
// usage
//   s_* beat: one starting point z (signed fixed point, FRAC_BITS fraction
//   bits). m_* beat: its iteration count. results leave in input order.
//   cfg_we/cfg_addr/cfg_data write c_re, c_im, the squared escape radius and
//   the iteration limit; write them only while no point is in flight.
// loop
//   one iteration is one pass round a five-stage loop (magnitudes, partial
//   products, product sums, escape test, scale and add c_re / subtract c_im).
//   five points share the loop, one per stage, so a new point can enter
//   before the earlier ones are finished.
//   a new point enters when the slot at the loop head is empty or retiring.
// reset
//   rst_n clears the loop, the sequence counters and the output beat, and
//   loads c = 0, squared radius 4.0 and limit 256.
// stall
//   a finished point waits in its slot, circling the loop, until it is the
//   oldest and the output register is free; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module julia_escape_time_iterator_core
    import jeti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input beats
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,  // z_re, z_im
    // result beats
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [COUNT_W-1:0]                    m_tdata,  // iter_count
    // register writes
    input  logic                                  cfg_we,
    input  logic [CFG_IDX_W-1:0]                  cfg_addr,
    input  logic [COORD_WIDTH+1:0]                cfg_data
);

    localparam int ZW = COORD_WIDTH + 4;
    localparam int RW = COORD_WIDTH + 2;

    // configuration registers
    logic signed [COORD_WIDTH-1:0] c_re_reg;
    logic signed [COORD_WIDTH-1:0] c_re_next;
    logic signed [COORD_WIDTH-1:0] c_im_reg;
    logic signed [COORD_WIDTH-1:0] c_im_next;
    logic [RW-1:0]                 radius_sq_reg;
    logic [RW-1:0]                 radius_sq_next;
    logic [COUNT_W-1:0]            max_iters_reg;
    logic [COUNT_W-1:0]            max_iters_next;

    // order keeping
    logic [TAG_W-1:0] in_seq_reg;
    logic [TAG_W-1:0] in_seq_next;
    logic [TAG_W-1:0] out_seq_reg;
    logic [TAG_W-1:0] out_seq_next;

    // output beat register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_free;

    // loop head
    slot_t                loop_ctrl;
    logic signed [ZW-1:0] loop_re;
    logic signed [ZW-1:0] loop_im;
    logic                 loop_esc;
    slot_t                slot_ctrl;
    slot_t                enter_ctrl;
    logic signed [ZW-1:0] enter_re;
    logic signed [ZW-1:0] enter_im;
    logic                 retire;
    logic                 take;

    // ------------------------------------------------------------------------
    // register writes
    // ------------------------------------------------------------------------
    always_comb
    begin
        c_re_next      = c_re_reg;
        c_im_next      = c_im_reg;
        radius_sq_next = radius_sq_reg;
        max_iters_next = max_iters_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_C_RE:      c_re_next      = cfg_data[COORD_WIDTH-1:0];
                REG_C_IM:      c_im_next      = cfg_data[COORD_WIDTH-1:0];
                REG_RADIUS_SQ: radius_sq_next = cfg_data;
                REG_MAX_ITERS: max_iters_next = cfg_data[COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // loop head: decide, retire, admit
    // ------------------------------------------------------------------------
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        slot_ctrl = loop_ctrl;
        // a live slot stops on escape, or once it has reached the limit;
        // the first step is always taken when the start lies inside
        if (loop_ctrl.valid && !loop_ctrl.done)
        begin
            if (loop_esc || (loop_ctrl.count != '0 && loop_ctrl.count >= max_iters_reg))
            begin
                slot_ctrl.done = 1'b1;
            end
            else
            begin
                slot_ctrl.count = loop_ctrl.count + COUNT_W'(1);
            end
        end

        // only the oldest point may leave
        retire = slot_ctrl.valid && slot_ctrl.done
                 && (slot_ctrl.tag == out_seq_reg) && out_free;

        s_tready = !slot_ctrl.valid || retire;
        take     = s_tvalid && s_tready;

        enter_ctrl = slot_ctrl;
        enter_re   = loop_re;
        enter_im   = loop_im;
        if (retire)
        begin
            enter_ctrl.valid = 1'b0;
        end
        if (take)
        begin
            enter_ctrl.valid = 1'b1;
            enter_ctrl.done  = 1'b0;
            enter_ctrl.count = '0;
            enter_ctrl.tag   = in_seq_reg;
            enter_re         = ZW'($signed(s_tdata[COORD_WIDTH-1:0]));
            enter_im         = ZW'($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]));
        end
    end

    always_comb
    begin
        in_seq_next    = take ? in_seq_reg + TAG_W'(1) : in_seq_reg;
        out_seq_next   = retire ? out_seq_reg + TAG_W'(1) : out_seq_reg;
        out_valid_next = retire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    jeti_step #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ctrl     (enter_ctrl),
        .in_re       (enter_re),
        .in_im       (enter_im),
        .c_re        (c_re_reg),
        .c_im        (c_im_reg),
        .radius_sq   (radius_sq_reg),
        .out_ctrl    (loop_ctrl),
        .out_re      (loop_re),
        .out_im      (loop_im),
        .out_escaped (loop_esc)
    );

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_re_reg      <= '0;
            c_im_reg      <= '0;
            radius_sq_reg <= RW'(RADIUS_SQ_RESET);
            max_iters_reg <= MAX_ITERS_RESET;
            in_seq_reg    <= '0;
            out_seq_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            c_re_reg      <= c_re_next;
            c_im_reg      <= c_im_next;
            radius_sq_reg <= radius_sq_next;
            max_iters_reg <= max_iters_next;
            in_seq_reg    <= in_seq_next;
            out_seq_reg   <= out_seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            out_count_reg <= slot_ctrl.count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_count_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_in_flight_bound : assert property (@(posedge clk) disable iff (!rst_n)
        TAG_W'(in_seq_reg - out_seq_reg) <= TAG_W'(PIPE_STAGES))
        else $error("more points in flight than loop slots");

    a_live_slot_counted : assert property (@(posedge clk) disable iff (!rst_n)
        loop_ctrl.valid |-> (in_seq_reg != out_seq_reg))
        else $error("live slot with no point outstanding");

    a_count_within_limit : assert property (@(posedge clk) disable iff (!rst_n)
        retire |-> (slot_ctrl.count <= max_iters_reg || slot_ctrl.count == COUNT_W'(1)))
        else $error("result beyond iteration limit");

    a_retire_loads_output : assert property (@(posedge clk) disable iff (!rst_n)
        retire |=> (m_tvalid && m_tdata == $past(slot_ctrl.count)))
        else $error("retired count not presented");

endmodule : julia_escape_time_iterator_core

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the julia escape-time iterator core: starting points
// go in as stream beats, every iteration count coming back is checked against
// an in-bench fixed-point iteration of the same set, across several constants,
// radii and iteration limits, with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import jeti_pkg::*;

    localparam int CW      = COORD_WIDTH_DEF;
    localparam int FB      = FRAC_BITS_DEF;
    localparam int TDATA_W = ((2*CW+7)/8)*8;

    // handy q4.28 values
    localparam logic [CW-1:0] Q_ZERO    = 32'h0000_0000;
    localparam logic [CW-1:0] Q_ONE     = 32'h1000_0000;
    localparam logic [CW-1:0] Q_NEG_ONE = 32'hF000_0000;
    localparam logic [CW-1:0] Q_TWO     = 32'h2000_0000;
    localparam logic [CW-1:0] Q_NEG_TWO = 32'hE000_0000;
    localparam logic [CW-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] Q_MIN     = 32'h8000_0000;
    localparam logic [CW-1:0] Q_LSB     = 32'h0000_0001;
    localparam logic [CW-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;

    localparam logic [CW+1:0] RADIUS_4  = 34'd1073741824;   // 4.0 squared radius
    localparam logic [CW+1:0] RADIUS_0  = 34'd0;
    localparam logic [CW+1:0] RADIUS_HI = {(CW+2){1'b1}};

    localparam int RANDOM_PER_PHASE = 255;

    // ------------------------------------------------------------------------
    // clock, reset and block interface
    // ------------------------------------------------------------------------
    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;

    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;      // z_re, z_im

    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [COUNT_W-1:0] m_tdata;            // iter_count

    logic               cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CW+1:0]      cfg_data = '0;

    always #1 clk = ~clk;

    julia_escape_time_iterator_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    // register mirror, loaded with the reset values
    logic signed [CW-1:0] c_re_cfg      = '0;
    logic signed [CW-1:0] c_im_cfg      = '0;
    logic [CW+1:0]        radius_sq_cfg = RADIUS_SQ_RESET[CW+1:0];
    logic [COUNT_W-1:0]   iter_limit    = MAX_ITERS_RESET;

    logic [TDATA_W-1:0]   start_points[$];      // points waiting to be sent
    logic [COUNT_W-1:0]   expected_counts[$];   // counts of points in flight
    logic [COUNT_W-1:0]   count_want;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          failures      = 0;

    // ------------------------------------------------------------------------
    // escape-time iteration at full width
    // 128-bit signed working values: z grows to about 2^35 before the test
    // catches it, so its square never comes near the top
    // ------------------------------------------------------------------------
    function automatic logic [COUNT_W-1:0] escape_count(
        input logic signed [CW-1:0] start_re,
        input logic signed [CW-1:0] start_im
    );
        logic signed [127:0] re;
        logic signed [127:0] im;
        logic signed [127:0] rr;
        logic signed [127:0] ii;
        logic signed [127:0] ri;
        logic signed [127:0] radius_fx;
        int unsigned         n;
        re        = 128'(start_re);
        im        = 128'(start_im);
        radius_fx = {94'd0, radius_sq_cfg};
        radius_fx = radius_fx <<< FB;
        // start already outside: nothing counted, whatever the limit
        if (re*re + im*im > radius_fx)
            return '0;
        n = 0;
        // first step is always taken, so a limit of 0 or 1 still gives 1
        do
        begin
            rr = re * re;
            ii = im * im;
            ri = re * im;
            // arithmetic shifts round toward minus infinity
            re = ((rr - ii) >>> FB) + 128'(c_re_cfg);
            im = ((ri <<< 1) >>> FB) - 128'(c_im_cfg);
            n++;
        end
        while (n < 32'(iter_limit) && re*re + im*im <= radius_fx);
        return n[COUNT_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // input driver: one beat per handshake, random gaps between beats
    // the expected count is worked out on acceptance, with the live registers
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_counts.push_back(escape_count(s_tdata[CW-1:0], s_tdata[2*CW-1:CW]));
            if (!s_tvalid || s_tready)
            begin
                if (start_points.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= start_points.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: random back-pressure, each beat against the oldest count
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $error("iter_count beat with no point in flight: got %0d", m_tdata);
                    failures++;
                end
                else
                begin
                    count_want = expected_counts.pop_front();
                    if (m_tdata !== count_want)
                    begin
                        $error("iter_count mismatch: expected %0d, got %0d",
                               count_want, m_tdata);
                        failures++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // one register write, mirrored once the block has taken it
    task automatic write_reg(input cfg_reg_t idx, input logic [CW+1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_C_RE:      c_re_cfg      = value[CW-1:0];
            REG_C_IM:      c_im_cfg      = value[CW-1:0];
            REG_RADIUS_SQ: radius_sq_cfg = value;
            REG_MAX_ITERS: iter_limit    = value[COUNT_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic set_config(input logic [CW-1:0] c_re, input logic [CW-1:0] c_im,
                              input logic [CW+1:0] radius_sq, input logic [COUNT_W-1:0] limit);
        write_reg(REG_C_RE,      {{2{c_re[CW-1]}}, c_re});
        write_reg(REG_C_IM,      {{2{c_im[CW-1]}}, c_im});
        write_reg(REG_RADIUS_SQ, radius_sq);
        write_reg(REG_MAX_ITERS, {{(CW+2-COUNT_W){1'b0}}, limit});
    endtask

    task automatic push_point(input logic [CW-1:0] re, input logic [CW-1:0] im);
        start_points.push_back({im, re});
    endtask

    // sender held back until every count is home and the loop has emptied
    task automatic wait_idle();
        while (start_points.size() != 0 || s_tvalid || expected_counts.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // mostly points with both parts within [-2, 2] where the orbits get interesting,
    // plus raw words, points near the origin and the corner values
    function automatic logic [CW-1:0] random_coord();
        int unsigned  pick;
        logic [CW-1:0] v;
        pick = $urandom_range(99);
        if (pick < 70)
            v = $urandom_range(32'h4000_0000) - 32'h2000_0000;
        else if (pick < 80)
            v = $urandom();
        else if (pick < 90)
            v = $urandom_range(32'h1000_0000) - 32'h0800_0000;
        else
        begin
            case ($urandom_range(6))
                0:       v = Q_ZERO;
                1:       v = Q_MAX;
                2:       v = Q_MIN;
                3:       v = Q_TWO;
                4:       v = Q_NEG_TWO;
                5:       v = Q_LSB;
                default: v = Q_NEG_LSB;
            endcase
        end
        return v;
    endfunction

    task automatic push_random_points(input int n);
        for (int k = 0; k < n; k++)
            push_point(random_coord(), random_coord());
    endtask

    function automatic logic [CW-1:0] random_c();
        return $urandom_range(32'h4000_0000) - 32'h2000_0000;
    endfunction

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CW+1:0] radius_rand;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalling
        send_idle_pct = 21;
        recv_idle_pct = 87;

        // reset registers: c = 0, radius 2.0, limit 256
        push_point(Q_ZERO, Q_ZERO);                   // fixed point at the origin
        push_point(Q_TWO, Q_ZERO);                    // exactly on the radius
        push_point(Q_TWO + 1, Q_ZERO);                // one lsb outside
        push_point(Q_ZERO, Q_NEG_TWO);                // on the radius, imaginary axis
        push_point(Q_MAX, Q_MAX);
        push_point(Q_MIN, Q_MIN);
        push_point(Q_MIN, Q_ZERO);
        push_point(Q_LSB, Q_NEG_LSB);                 // tiny, floors away to zero
        push_point(Q_NEG_LSB, Q_ZERO);
        push_point(Q_ONE, Q_ZERO);                    // 1 is its own square
        push_point(Q_NEG_ONE, Q_ZERO);
        push_point(32'h0B50_4F33, 32'h0B50_4F33);     // on the unit circle
        push_point(32'h16A0_9E66, 32'h16A0_9E66);     // close to the radius
        wait_idle();

        // constant at its corners, widest radius, limit of one
        set_config(Q_MAX, Q_MIN, RADIUS_HI, 16'd1);
        push_point(Q_ZERO, Q_ZERO);
        push_point(Q_MAX, Q_ZERO);
        push_point(Q_MIN, Q_MIN);
        push_point(Q_MAX, Q_MIN);
        wait_idle();

        // zero radius, limit of zero: only the origin survives the first test
        set_config(Q_MIN, Q_MAX, RADIUS_0, 16'd0);
        push_point(Q_ZERO, Q_ZERO);
        push_point(Q_LSB, Q_ZERO);
        push_point(Q_ZERO, Q_NEG_LSB);
        wait_idle();

        // top limit: one point that never escapes, the rest short
        set_config(Q_ZERO, Q_ZERO, RADIUS_4, 16'hFFFF);
        push_point(Q_ZERO, Q_ZERO);
        push_point(Q_MAX, Q_ZERO);
        push_point(32'h1800_0000, Q_ZERO);
        wait_idle();

        // random points, classic connected julia constant
        set_config(-32'sd214748365, 32'sd41875931, RADIUS_4, 16'd256);
        push_random_points(RANDOM_PER_PHASE);
        wait_idle();

        // random constant, short limits
        set_config(random_c(), random_c(), RADIUS_4, 16'($urandom_range(40, 2)));
        push_random_points(RANDOM_PER_PHASE);
        wait_idle();

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 87;
        recv_idle_pct = 21;

        radius_rand = {2'b00, 32'($urandom_range(32'hFFFF_FFFF, 32'h1000_0000))};
        set_config(-32'sd107374182, 32'sd161061274, radius_rand, 16'd100);
        push_random_points(RANDOM_PER_PHASE);
        wait_idle();

        // any constant at all, widest radius so z grows large before escaping
        set_config($urandom(), $urandom(), RADIUS_HI, 16'd20);
        push_random_points(RANDOM_PER_PHASE);
        wait_idle();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;

        set_config(32'sd76504105, 32'sd2684355, RADIUS_4, 16'd300);
        push_random_points(RANDOM_PER_PHASE);
        wait_idle();

        radius_rand[CW+1:CW] = 2'($urandom_range(3));
        radius_rand[CW-1:0]  = $urandom();
        set_config(random_c(), random_c(), radius_rand, 16'($urandom_range(64)));
        push_random_points(RANDOM_PER_PHASE);
        wait_idle();

        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule : tb_top
